/* sv/gif_palette_to_argb_expander_macros.svh */
// Assertion macros used by the checker file of the palette expander.
`ifndef GIF_PALETTE_TO_ARGB_EXPANDER_MACROS_SVH
`define GIF_PALETTE_TO_ARGB_EXPANDER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GPAE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GPAE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/gpae_pkg.sv */
package gpae_pkg;

    localparam int MAX_DIM_DEFAULT       = 4096;
    localparam int PALETTE_DEPTH_DEFAULT = 256;

    localparam int CMD_W      = 2;
    localparam int COLOR_W    = 8;
    localparam int COORD_W    = 12;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CMD_W-1:0] CMD_PALETTE_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PROGRESSIVE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INTERLACED    = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_CANVAS_WIDTH      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CANVAS_HEIGHT     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_LEFT        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_TOP         = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_TRANSPARENT_INDEX = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_BACKGROUND_INDEX  = 3'd7;

    localparam logic [COLOR_W-1:0] ALPHA_OPAQUE      = 8'hFF;
    localparam logic [COLOR_W-1:0] ALPHA_TRANSPARENT = 8'h00;

    // Interlace passes: first row and row step of each pass.
    localparam logic [3:0] PASS_START [4] = '{4'd0, 4'd4, 4'd2, 4'd1};
    localparam logic [3:0] PASS_STEP  [4] = '{4'd8, 4'd8, 4'd4, 4'd2};

endpackage

/* sv/gif_palette_to_argb_expander.sv */
// Palette writes and pixels share the input channel.
// Throughput: one item per cycle while the output is not stalled by m_ready.
// The palette read and the output register each add one stage; a waiting result still
// lets the input stage take one more item before s_ready drops.
// Reset (aresetn low, synchronous) clears the walk position, the pipeline valids and the
// registers to their defaults; the palette is not cleared and holds garbage until written.
module gif_palette_to_argb_expander #(
    parameter int MAX_DIM       = gpae_pkg::MAX_DIM_DEFAULT,
    parameter int PALETTE_DEPTH = gpae_pkg::PALETTE_DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [gpae_pkg::CFG_ADDR_W-1:0]   cfg_index,
    input  logic [gpae_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [gpae_pkg::CMD_W-1:0]        s_command,
    input  logic [gpae_pkg::COLOR_W-1:0]      s_palette_slot,
    input  logic [gpae_pkg::COLOR_W-1:0]      s_palette_red,
    input  logic [gpae_pkg::COLOR_W-1:0]      s_palette_green,
    input  logic [gpae_pkg::COLOR_W-1:0]      s_palette_blue,
    input  logic [gpae_pkg::COLOR_W-1:0]      s_pixel_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [gpae_pkg::COLOR_W-1:0]      m_alpha,
    output logic [gpae_pkg::COLOR_W-1:0]      m_red,
    output logic [gpae_pkg::COLOR_W-1:0]      m_green,
    output logic [gpae_pkg::COLOR_W-1:0]      m_blue,
    output logic [gpae_pkg::COORD_W-1:0]      m_column,
    output logic [gpae_pkg::COORD_W-1:0]      m_row,
    output logic                              m_last_pixel
);
    import gpae_pkg::*;

    localparam int CW  = $clog2(MAX_DIM);
    localparam int SW  = CW + 1;
    localparam int WW  = (SW > CFG_DATA_W) ? SW : CFG_DATA_W;
    localparam int XW  = (SW > 14) ? SW : 14;
    localparam int AW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int RGB_W = 3 * COLOR_W;

    // Configuration registers.
    logic [12:0] canvas_width_reg;
    logic [12:0] canvas_height_reg;
    logic [11:0] frame_left_reg;
    logic [11:0] frame_top_reg;
    logic [12:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic [8:0]  transparent_index_reg;
    logic [7:0]  background_index_reg;

    // Walk state.
    logic [CW-1:0] column_reg, column_next;
    logic [CW-1:0] row_reg, row_next;
    logic [1:0]    pass_reg, pass_next;
    logic          last_next;

    // First stage: palette read data and everything known at acceptance.
    logic             s1_valid_reg, s1_valid_next;
    logic [RGB_W-1:0] s1_rgb_reg;
    logic             s1_in_range_reg;
    logic             s1_clear_reg;
    logic [CW-1:0]    s1_column_reg;
    logic [CW-1:0]    s1_row_reg;
    logic             s1_last_reg;

    // Output stage.
    logic               m_valid_reg, m_valid_next;
    logic [COLOR_W-1:0] m_alpha_reg;
    logic [RGB_W-1:0]   m_rgb_reg;
    logic [COORD_W-1:0] m_column_reg;
    logic [COORD_W-1:0] m_row_reg;
    logic               m_last_reg;

    logic [RGB_W-1:0] palette_mem [PALETTE_DEPTH];

    logic               s_accept;
    logic               is_pixel;
    logic               is_write;
    logic               out_load;
    logic               in_frame;
    logic [COLOR_W-1:0] pix_index;
    logic               pix_in_range;
    logic               slot_in_range;
    logic               pix_clear;
    logic [SW-1:0]      canvas_w;
    logic [SW-1:0]      canvas_h;
    logic [SW-1:0]      column_inc;
    logic [SW-1:0]      row_inc;
    logic [SW-1:0]      row_stepped;
    logic [XW-1:0]      row_x;
    logic [XW-1:0]      column_x;
    logic [XW-1:0]      top_x;
    logic [XW-1:0]      left_x;
    logic               found_pass;
    logic [1:0]         new_pass;

    function automatic logic [SW-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] value);
        logic [WW-1:0] ext;
        ext = WW'(value);
        if (ext == '0) begin
            return SW'(1);
        end else if (ext > WW'(MAX_DIM)) begin
            return SW'(MAX_DIM);
        end
        return SW'(ext);
    endfunction

    assign is_pixel = s_command inside {CMD_PROGRESSIVE, CMD_INTERLACED};
    assign is_write = (s_command == CMD_PALETTE_WRITE);
    assign out_load = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = aresetn && (!s1_valid_reg || !m_valid_reg || m_ready);
    assign s_accept = s_valid && s_ready;

    assign canvas_w = clamp_dim(canvas_width_reg);
    assign canvas_h = clamp_dim(canvas_height_reg);

    // Frame rectangle test, only applied to progressive items.
    assign row_x    = XW'(row_reg);
    assign column_x = XW'(column_reg);
    assign top_x    = XW'(frame_top_reg);
    assign left_x   = XW'(frame_left_reg);
    assign in_frame = (row_x >= top_x) && (row_x < top_x + XW'(frame_height_reg))
                   && (column_x >= left_x) && (column_x < left_x + XW'(frame_width_reg));

    assign pix_index = ((s_command == CMD_PROGRESSIVE) && !in_frame)
                     ? background_index_reg : s_pixel_index;
    assign pix_in_range  = {1'b0, pix_index} < 9'(PALETTE_DEPTH);
    assign slot_in_range = {1'b0, s_palette_slot} < 9'(PALETTE_DEPTH);
    // A negative transparent index never matches.
    assign pix_clear = !transparent_index_reg[8] && (pix_index == transparent_index_reg[7:0]);

    assign column_inc  = SW'(column_reg) + SW'(1);
    assign row_inc     = SW'(row_reg) + SW'(1);
    assign row_stepped = SW'(row_reg) + SW'(PASS_STEP[pass_reg]);

    // First later pass whose start row still lies on the canvas.
    always_comb begin
        found_pass = 1'b0;
        new_pass   = '0;
        for (int q = 3; q >= 1; q--) begin
            if ((2'(q) > pass_reg) && (SW'(PASS_START[q]) < canvas_h)) begin
                found_pass = 1'b1;
                new_pass   = 2'(q);
            end
        end
    end

    always_comb begin
        column_next = column_reg;
        row_next    = row_reg;
        pass_next   = pass_reg;
        last_next   = 1'b0;
        if (column_inc < canvas_w) begin
            column_next = column_inc[CW-1:0];
        end else begin
            column_next = '0;
            if (s_command == CMD_PROGRESSIVE) begin
                if (row_inc < canvas_h) begin
                    row_next = row_inc[CW-1:0];
                end else begin
                    row_next  = '0;
                    pass_next = '0;
                    last_next = 1'b1;
                end
            end else if (row_stepped < canvas_h) begin
                row_next = row_stepped[CW-1:0];
            end else if (found_pass) begin
                pass_next = new_pass;
                row_next  = CW'(PASS_START[new_pass]);
            end else begin
                row_next  = '0;
                pass_next = '0;
                last_next = 1'b1;
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = is_pixel;
        end else if (out_load) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            canvas_width_reg      <= 13'd1;
            canvas_height_reg     <= 13'd1;
            frame_left_reg        <= '0;
            frame_top_reg         <= '0;
            frame_width_reg       <= 13'd1;
            frame_height_reg      <= 13'd1;
            transparent_index_reg <= 9'h1FF;
            background_index_reg  <= '0;
            column_reg            <= '0;
            row_reg               <= '0;
            pass_reg              <= '0;
            s1_valid_reg          <= 1'b0;
            m_valid_reg           <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CANVAS_WIDTH:      canvas_width_reg      <= cfg_wdata;
                    REG_CANVAS_HEIGHT:     canvas_height_reg     <= cfg_wdata;
                    REG_FRAME_LEFT:        frame_left_reg        <= cfg_wdata[11:0];
                    REG_FRAME_TOP:         frame_top_reg         <= cfg_wdata[11:0];
                    REG_FRAME_WIDTH:       frame_width_reg       <= cfg_wdata;
                    REG_FRAME_HEIGHT:      frame_height_reg      <= cfg_wdata;
                    REG_TRANSPARENT_INDEX: transparent_index_reg <= cfg_wdata[8:0];
                    REG_BACKGROUND_INDEX:  background_index_reg  <= cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
            if (s_accept && is_pixel) begin
                column_reg <= column_next;
                row_reg    <= row_next;
                pass_reg   <= pass_next;
            end
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Palette memory: one write port for palette items, one registered read for pixels.
    always_ff @(posedge aclk) begin
        if (s_accept && is_write && slot_in_range) begin
            palette_mem[s_palette_slot[AW-1:0]] <= {s_palette_red, s_palette_green,
                                                   s_palette_blue};
        end
        if (s_accept && is_pixel) begin
            s1_rgb_reg <= palette_mem[pix_index[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && is_pixel) begin
            s1_in_range_reg <= pix_in_range;
            s1_clear_reg    <= pix_clear;
            s1_column_reg   <= column_reg;
            s1_row_reg      <= row_reg;
            s1_last_reg     <= last_next;
        end
        if (out_load) begin
            m_alpha_reg  <= s1_clear_reg ? ALPHA_TRANSPARENT : ALPHA_OPAQUE;
            m_rgb_reg    <= s1_in_range_reg ? s1_rgb_reg : '0;
            m_column_reg <= COORD_W'(s1_column_reg);
            m_row_reg    <= COORD_W'(s1_row_reg);
            m_last_reg   <= s1_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_alpha      = m_alpha_reg;
    assign m_red        = m_rgb_reg[3*COLOR_W-1:2*COLOR_W];
    assign m_green      = m_rgb_reg[2*COLOR_W-1:COLOR_W];
    assign m_blue       = m_rgb_reg[COLOR_W-1:0];
    assign m_column     = m_column_reg;
    assign m_row        = m_row_reg;
    assign m_last_pixel = m_last_reg;

endmodule

/* sv/gpae_checker.sv */
`include "gif_palette_to_argb_expander_macros.svh"

module gpae_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              cfg_wr_en,
    input logic [gpae_pkg::CFG_ADDR_W-1:0]   cfg_index,
    input logic [gpae_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [gpae_pkg::CMD_W-1:0]        s_command,
    input logic [gpae_pkg::COLOR_W-1:0]      s_palette_slot,
    input logic [gpae_pkg::COLOR_W-1:0]      s_palette_red,
    input logic [gpae_pkg::COLOR_W-1:0]      s_palette_green,
    input logic [gpae_pkg::COLOR_W-1:0]      s_palette_blue,
    input logic [gpae_pkg::COLOR_W-1:0]      s_pixel_index,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [gpae_pkg::COLOR_W-1:0]      m_alpha,
    input logic [gpae_pkg::COLOR_W-1:0]      m_red,
    input logic [gpae_pkg::COLOR_W-1:0]      m_green,
    input logic [gpae_pkg::COLOR_W-1:0]      m_blue,
    input logic [gpae_pkg::COORD_W-1:0]      m_column,
    input logic [gpae_pkg::COORD_W-1:0]      m_row,
    input logic                              m_last_pixel
);
    import gpae_pkg::*;

    logic pixel_accept;
    logic pixel_accept_d1_reg;
    logic pixel_accept_d2_reg;

    assign pixel_accept = s_valid && s_ready
                       && ((s_command == CMD_PROGRESSIVE) || (s_command == CMD_INTERLACED));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_accept_d1_reg <= 1'b0;
            pixel_accept_d2_reg <= 1'b0;
        end else begin
            pixel_accept_d1_reg <= pixel_accept;
            pixel_accept_d2_reg <= pixel_accept_d1_reg;
        end
    end

    // A stalled result keeps its contents.
    `GPAE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_alpha) && $stable(m_red) && $stable(m_green) && $stable(m_blue) && $stable(m_column) && $stable(m_row) && $stable(m_last_pixel), "result changed while stalled")

    // An empty output register only fills when pixel_accept_d2_reg marks a pixel item.
    `GPAE_ASSERT_NOW(a_out_source, aclk, aresetn, $rose(m_valid), pixel_accept_d2_reg, "result appeared without a pixel item")

    // The input side only backs up when both stages are full and the output is blocked.
    `GPAE_ASSERT_NOW(a_ready_backpressure, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled without output backpressure")

    `GPAE_ASSERT_NOW(a_alpha_levels, aclk, aresetn, m_valid, (m_alpha == ALPHA_OPAQUE) || (m_alpha == ALPHA_TRANSPARENT), "alpha is neither opaque nor transparent")

endmodule

bind gif_palette_to_argb_expander gpae_checker u_gpae_checker (.*);
